// ===== sv/sbfh_pkg.sv =====
`default_nettype none
package sbfh_pkg;

    // Status of the queue between the front end and the search engine.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_STEP
    } t_back_state;

endpackage
`default_nettype wire

// ===== sv/sbfh_queue.sv =====
`default_nettype none
module sbfh_queue #(
    parameter int WIDTH = 132,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output sbfh_pkg::t_qstat      o_stat
);
    import sbfh_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [AW:0]      n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (AW+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule
`default_nettype wire

// ===== sv/sbfh_front.sv =====
`default_nettype none
module sbfh_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] i_obstacle_top,
    input  wire logic signed [COORD_BITS-1:0] i_obstacle_left,
    input  wire logic signed [COORD_BITS-1:0] i_obstacle_bottom,
    input  wire logic signed [COORD_BITS-1:0] i_obstacle_right,
    input  wire logic signed [COORD_BITS-1:0] i_mover_left,
    input  wire logic signed [COORD_BITS-1:0] i_mover_top,
    input  wire logic        [COORD_BITS-2:0] i_mover_width,
    input  wire logic        [COORD_BITS-2:0] i_mover_height,
    input  wire logic signed [COORD_BITS-1:0] i_target_x,
    input  wire logic signed [COORD_BITS-1:0] i_target_y,
    input  sbfh_pkg::t_qstat                  i_qstat,
    output logic                              o_push,
    output logic [11*COORD_BITS-1:0]          o_entry
);
    import sbfh_pkg::*;

    localparam int CB = COORD_BITS;

    logic                 r_fv;
    logic                 n_fv;
    logic signed [CB-1:0] r_t0, r_l0, r_b0, r_r0, r_sx, r_sy, r_tx, r_ty;
    logic        [CB-2:0] r_w, r_h;

    logic signed [CB-1:0] ot, ob, ol, orr;
    logic signed [CB:0]   dist_x, dist_y;
    logic        [CB:0]   mag_x, mag_y;
    logic        [CB-1:0] ax, ay, len;
    logic                 accept;

    assign o_push = r_fv && !i_qstat.full;
    assign busy   = r_fv && i_qstat.full;
    assign accept = start && !busy;

    always_comb begin
        n_fv = r_fv;
        if (accept) begin
            n_fv = 1'b1;
        end else if (o_push) begin
            n_fv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_t0 <= i_obstacle_top;
            r_l0 <= i_obstacle_left;
            r_b0 <= i_obstacle_bottom;
            r_r0 <= i_obstacle_right;
            r_sx <= i_mover_left;
            r_sy <= i_mover_top;
            r_w  <= i_mover_width;
            r_h  <= i_mover_height;
            r_tx <= i_target_x;
            r_ty <= i_target_y;
        end
    end

    // Order the obstacle edges and reduce the path to magnitudes and signs.
    always_comb begin
        ot     = (r_t0 < r_b0) ? r_t0 : r_b0;
        ob     = (r_t0 < r_b0) ? r_b0 : r_t0;
        ol     = (r_l0 < r_r0) ? r_l0 : r_r0;
        orr    = (r_l0 < r_r0) ? r_r0 : r_l0;
        dist_x = {r_tx[CB-1], r_tx} - {r_sx[CB-1], r_sx};
        dist_y = {r_ty[CB-1], r_ty} - {r_sy[CB-1], r_sy};
        mag_x  = dist_x[CB] ? (CB+1)'(-dist_x) : dist_x;
        mag_y  = dist_y[CB] ? (CB+1)'(-dist_y) : dist_y;
        ax     = mag_x[CB-1:0];
        ay     = mag_y[CB-1:0];
        len    = (ax > ay) ? ax : ay;
    end

    assign o_entry = {ot, ob, ol, orr, r_sx, r_sy, r_w, r_h,
                      dist_x[CB], dist_y[CB], ax, ay, len};

endmodule
`default_nettype wire

// ===== sv/sbfh_back.sv =====
`default_nettype none
module sbfh_back #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [11*COORD_BITS-1:0]    i_entry,
    input  sbfh_pkg::t_qstat                 i_qstat,
    output logic                             o_pop,
    output logic                             o_valid,
    output logic                             o_hit,
    output logic signed [COORD_BITS-1:0]     o_hit_x,
    output logic signed [COORD_BITS-1:0]     o_hit_y
);
    import sbfh_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int PW  = CB + FB + 1;
    localparam int SW  = FB + 2;
    localparam int DCW = $clog2(FB);
    localparam logic [PW-1:0] HALF = PW'(1) << (FB - 1);

    // Queue head fields.
    logic signed [CB-1:0] e_ot, e_ob, e_ol, e_or, e_sx, e_sy;
    logic        [CB-2:0] e_w, e_h;
    logic                 e_negx, e_negy;
    logic        [CB-1:0] e_ax, e_ay, e_len;

    assign {e_ot, e_ob, e_ol, e_or, e_sx, e_sy, e_w, e_h,
            e_negx, e_negy, e_ax, e_ay, e_len} = i_entry;

    t_back_state r_state, n_state;

    logic signed [CB-1:0] r_ot, r_ob, r_ol, r_or, r_sx, r_sy;
    logic signed [CB-1:0] n_ot, n_ob, n_ol, n_or, n_sx, n_sy;
    logic        [CB-2:0] r_w, r_h, n_w, n_h;
    logic                 r_negx, r_negy, n_negx, n_negy;
    logic        [CB-1:0] r_len, n_len;
    logic        [CB-1:0] r_remx, r_remy, n_remx, n_remy;
    logic        [FB:0]   r_qx, r_qy, n_qx, n_qy;
    logic        [DCW-1:0] r_dcnt, n_dcnt;
    logic signed [SW-1:0] r_stepx, r_stepy, n_stepx, n_stepy;
    logic signed [PW-1:0] r_px, r_py, n_px, n_py;
    logic        [CB-1:0] r_k, n_k;
    logic                 r_av, n_av, r_bv, n_bv;
    logic signed [CB:0]   r_rx, r_ry, n_rx, n_ry;
    logic                 r_valid, n_valid, r_hit, n_hit;
    logic signed [CB-1:0] r_hx, r_hy, n_hx, n_hy;

    logic        [CB:0]   tx2, ty2;
    logic                 bitx, bity;
    logic        [PW-1:0] rndx, rndy;
    logic signed [CB+1:0] rx_far, ry_far;
    logic                 overlap;

    always_comb begin
        // One restoring division step per axis.
        tx2  = {r_remx, 1'b0};
        ty2  = {r_remy, 1'b0};
        bitx = (tx2 >= {1'b0, r_len});
        bity = (ty2 >= {1'b0, r_len});

        // Round half away from zero: bias by a half, less one for negatives.
        rndx = r_px + HALF - PW'(r_px[PW-1]);
        rndy = r_py + HALF - PW'(r_py[PW-1]);

        rx_far  = {r_rx[CB], r_rx} + signed'({3'b000, r_w});
        ry_far  = {r_ry[CB], r_ry} + signed'({3'b000, r_h});
        overlap = (r_rx <= signed'({r_or[CB-1], r_or}))
               && (rx_far >= signed'({{2{r_ol[CB-1]}}, r_ol}))
               && (r_ry <= signed'({r_ob[CB-1], r_ob}))
               && (ry_far >= signed'({{2{r_ot[CB-1]}}, r_ot}));
    end

    always_comb begin
        n_state = r_state;
        n_ot = r_ot;  n_ob = r_ob;  n_ol = r_ol;  n_or = r_or;
        n_sx = r_sx;  n_sy = r_sy;  n_w = r_w;    n_h = r_h;
        n_negx = r_negx;  n_negy = r_negy;  n_len = r_len;
        n_remx = r_remx;  n_remy = r_remy;  n_qx = r_qx;  n_qy = r_qy;
        n_dcnt = r_dcnt;
        n_stepx = r_stepx;  n_stepy = r_stepy;
        n_px = r_px;  n_py = r_py;  n_k = r_k;
        n_av = r_av;  n_bv = r_bv;  n_rx = r_rx;  n_ry = r_ry;
        n_valid = 1'b0;
        n_hit = r_hit;  n_hx = r_hx;  n_hy = r_hy;
        o_pop = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop  = 1'b1;
                    n_ot = e_ot;  n_ob = e_ob;  n_ol = e_ol;  n_or = e_or;
                    n_sx = e_sx;  n_sy = e_sy;  n_w = e_w;    n_h = e_h;
                    n_negx = e_negx;  n_negy = e_negy;  n_len = e_len;
                    // A full-length axis has the exact quotient one.
                    n_remx = (e_ax == e_len) ? '0 : e_ax;
                    n_remy = (e_ay == e_len) ? '0 : e_ay;
                    n_qx   = (e_ax == e_len) ? (FB+1)'(1) : '0;
                    n_qy   = (e_ay == e_len) ? (FB+1)'(1) : '0;
                    n_dcnt = '0;
                    if (e_len == '0) begin
                        n_valid = 1'b1;
                        n_hit   = 1'b0;
                        n_hx    = '0;
                        n_hy    = '0;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_remx = bitx ? CB'(tx2 - {1'b0, r_len}) : tx2[CB-1:0];
                n_remy = bity ? CB'(ty2 - {1'b0, r_len}) : ty2[CB-1:0];
                n_qx   = {r_qx[FB-1:0], bitx};
                n_qy   = {r_qy[FB-1:0], bity};
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DCW'(FB - 1)) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_stepx = r_negx ? -signed'({1'b0, r_qx}) : signed'({1'b0, r_qx});
                n_stepy = r_negy ? -signed'({1'b0, r_qy}) : signed'({1'b0, r_qy});
                n_px    = signed'({r_sx[CB-1], r_sx, {FB{1'b0}}});
                n_py    = signed'({r_sy[CB-1], r_sy, {FB{1'b0}}});
                n_k     = '0;
                n_av    = 1'b0;
                n_bv    = 1'b0;
                n_state = ST_STEP;
            end
            ST_STEP: begin
                // Three-deep pipe: advance, round, test.
                if (r_k != r_len) begin
                    n_px = r_px + PW'(r_stepx);
                    n_py = r_py + PW'(r_stepy);
                    n_k  = r_k + 1'b1;
                    n_av = 1'b1;
                end else begin
                    n_av = 1'b0;
                end
                n_rx = signed'(rndx[PW-1:FB]);
                n_ry = signed'(rndy[PW-1:FB]);
                n_bv = r_av;
                if (r_bv && overlap) begin
                    n_valid = 1'b1;
                    n_hit   = 1'b1;
                    n_hx    = r_rx[CB-1:0];
                    n_hy    = r_ry[CB-1:0];
                    n_state = ST_IDLE;
                end else if (!r_av && !r_bv && (r_k == r_len)) begin
                    n_valid = 1'b1;
                    n_hit   = 1'b0;
                    n_hx    = '0;
                    n_hy    = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ot <= n_ot;  r_ob <= n_ob;  r_ol <= n_ol;  r_or <= n_or;
        r_sx <= n_sx;  r_sy <= n_sy;  r_w <= n_w;    r_h <= n_h;
        r_negx <= n_negx;  r_negy <= n_negy;  r_len <= n_len;
        r_remx <= n_remx;  r_remy <= n_remy;  r_qx <= n_qx;  r_qy <= n_qy;
        r_dcnt <= n_dcnt;
        r_stepx <= n_stepx;  r_stepy <= n_stepy;
        r_px <= n_px;  r_py <= n_py;  r_k <= n_k;
        r_av <= n_av;  r_bv <= n_bv;  r_rx <= n_rx;  r_ry <= n_ry;
        r_hit <= n_hit;  r_hx <= n_hx;  r_hy <= n_hy;
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;
    assign o_hit_x = r_hx;
    assign o_hit_y = r_hy;

endmodule
`default_nettype wire

// ===== sv/swept_box_first_hit_search_top.sv =====
`default_nettype none
// Swept-box first-hit search.
// Input: a word is taken at a rising edge with start high and busy low. It
// carries the obstacle edges, the mover's start corner and size, and the
// target corner. The front end orders the obstacle edges and reduces the
// path to magnitudes, signs and the longer distance, then parks the word in a
// two-entry queue; busy rises only when the front register is loaded and the
// queue is full.
// Output: one result word per input word, shown for exactly one cycle with
// o_valid high; the receiver cannot stall it, and results leave in order.
// From the queue head an item passes a load state, the bit-serial step
// division (both axes in parallel), a setup state, then one path step per
// cycle through the advance, round and test stages, which drain before a
// miss is reported. A zero-length path answers from the load state. The
// time an item spends in the search engine grows with its path length, and
// the engine takes the next word from the queue only once it has answered.
// Reset empties the queue, returns both ends to idle and clears o_valid;
// nothing else is cleared.
module swept_box_first_hit_search_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] i_obstacle_top,
    input  wire logic signed [COORD_BITS-1:0] i_obstacle_left,
    input  wire logic signed [COORD_BITS-1:0] i_obstacle_bottom,
    input  wire logic signed [COORD_BITS-1:0] i_obstacle_right,
    input  wire logic signed [COORD_BITS-1:0] i_mover_left,
    input  wire logic signed [COORD_BITS-1:0] i_mover_top,
    input  wire logic        [COORD_BITS-2:0] i_mover_width,
    input  wire logic        [COORD_BITS-2:0] i_mover_height,
    input  wire logic signed [COORD_BITS-1:0] i_target_x,
    input  wire logic signed [COORD_BITS-1:0] i_target_y,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic signed [COORD_BITS-1:0]      o_hit_x,
    output logic signed [COORD_BITS-1:0]      o_hit_y
);
    import sbfh_pkg::*;

    localparam int ENTRY_W = 11 * COORD_BITS;
    localparam int Q_DEPTH = 2;

    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] entry_in;
    logic [ENTRY_W-1:0] entry_out;
    t_qstat             qstat;

    sbfh_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_obstacle_top    (i_obstacle_top),
        .i_obstacle_left   (i_obstacle_left),
        .i_obstacle_bottom (i_obstacle_bottom),
        .i_obstacle_right  (i_obstacle_right),
        .i_mover_left      (i_mover_left),
        .i_mover_top       (i_mover_top),
        .i_mover_width     (i_mover_width),
        .i_mover_height    (i_mover_height),
        .i_target_x        (i_target_x),
        .i_target_y        (i_target_y),
        .i_qstat           (qstat),
        .o_push            (push),
        .o_entry           (entry_in)
    );

    sbfh_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry_in),
        .i_pop   (pop),
        .o_data  (entry_out),
        .o_stat  (qstat)
    );

    sbfh_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (entry_out),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_hit   (o_hit),
        .o_hit_x (o_hit_x),
        .o_hit_y (o_hit_y)
    );

endmodule
`default_nettype wire

// ===== test/tb_swept_box_first_hit_search_top.sv =====
`default_nettype none
module tb_swept_box_first_hit_search_top;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 16;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;

    typedef struct {
        logic signed [COORD_BITS-1:0] obs_top;
        logic signed [COORD_BITS-1:0] obs_left;
        logic signed [COORD_BITS-1:0] obs_bottom;
        logic signed [COORD_BITS-1:0] obs_right;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic        [COORD_BITS-2:0] box_w;
        logic        [COORD_BITS-2:0] box_h;
        logic signed [COORD_BITS-1:0] goal_x;
        logic signed [COORD_BITS-1:0] goal_y;
    } path_word_t;

    typedef struct {
        logic                         hit;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } hit_report_t;

    class first_hit_scoreboard;
        hit_report_t awaited[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        static function longint round_half_away(longint v);
            longint one;
            one = longint'(1) <<< FRAC_BITS;
            if (v >= 0)
                return (v + one / 2) / one;
            return -((-v + one / 2) / one);
        endfunction

        // Walks the corner along the stepped line and reports the first
        // rounded position at which the box touches the obstacle.
        function hit_report_t predict_first_hit(path_word_t w);
            hit_report_t r;
            longint one, top, bot, lft, rgt, sx, sy, wd, ht, dx, dy, ax, ay, span;
            longint stx, sty, px, py, k;
            one = longint'(1) <<< FRAC_BITS;
            top = (w.obs_top < w.obs_bottom) ? w.obs_top : w.obs_bottom;
            bot = (w.obs_top < w.obs_bottom) ? w.obs_bottom : w.obs_top;
            lft = (w.obs_left < w.obs_right) ? w.obs_left : w.obs_right;
            rgt = (w.obs_left < w.obs_right) ? w.obs_right : w.obs_left;
            sx = w.start_x;
            sy = w.start_y;
            wd = longint'(w.box_w);
            ht = longint'(w.box_h);
            dx = longint'(w.goal_x) - sx;
            dy = longint'(w.goal_y) - sy;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            span = (ax > ay) ? ax : ay;
            r.hit = 1'b0;
            r.x = '0;
            r.y = '0;
            if (span == 0)
                return r;
            // Signed division truncates toward zero, as the step sizes need.
            stx = (dx * one) / span;
            sty = (dy * one) / span;
            for (k = 1; k <= span; k++) begin
                px = round_half_away(sx * one + k * stx);
                py = round_half_away(sy * one + k * sty);
                if (px <= rgt && px + wd >= lft && py <= bot && py + ht >= top) begin
                    r.hit = 1'b1;
                    r.x = px[COORD_BITS-1:0];
                    r.y = py[COORD_BITS-1:0];
                    return r;
                end
            end
            return r;
        endfunction

        function void note_word(path_word_t w);
            awaited.push_back(predict_first_hit(w));
        endfunction

        function void check_result(logic hit, logic signed [COORD_BITS-1:0] x,
                                   logic signed [COORD_BITS-1:0] y);
            hit_report_t exp;
            if (awaited.size() == 0) begin
                $display("%0t: result word with nothing expected: hit %0b x %0d y %0d",
                         $time, hit, x, y);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (hit !== exp.hit) begin
                $display("%0t: hit mismatch: expected %0b, actual %0b", $time, exp.hit, hit);
                errors++;
            end
            if (x !== exp.x) begin
                $display("%0t: hit_x mismatch: expected %0d, actual %0d", $time, exp.x, x);
                errors++;
            end
            if (y !== exp.y) begin
                $display("%0t: hit_y mismatch: expected %0d, actual %0d", $time, exp.y, y);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic signed [COORD_BITS-1:0] i_obstacle_top;
    logic signed [COORD_BITS-1:0] i_obstacle_left;
    logic signed [COORD_BITS-1:0] i_obstacle_bottom;
    logic signed [COORD_BITS-1:0] i_obstacle_right;
    logic signed [COORD_BITS-1:0] i_mover_left;
    logic signed [COORD_BITS-1:0] i_mover_top;
    logic        [COORD_BITS-2:0] i_mover_width;
    logic        [COORD_BITS-2:0] i_mover_height;
    logic signed [COORD_BITS-1:0] i_target_x;
    logic signed [COORD_BITS-1:0] i_target_y;
    logic                         o_valid;
    logic                         o_hit;
    logic signed [COORD_BITS-1:0] o_hit_x;
    logic signed [COORD_BITS-1:0] o_hit_y;

    first_hit_scoreboard sb;
    int cycle_count = 0;

    swept_box_first_hit_search_top #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_obstacle_top    (i_obstacle_top),
        .i_obstacle_left   (i_obstacle_left),
        .i_obstacle_bottom (i_obstacle_bottom),
        .i_obstacle_right  (i_obstacle_right),
        .i_mover_left      (i_mover_left),
        .i_mover_top       (i_mover_top),
        .i_mover_width     (i_mover_width),
        .i_mover_height    (i_mover_height),
        .i_target_x        (i_target_x),
        .i_target_y        (i_target_y),
        .o_valid           (o_valid),
        .o_hit             (o_hit),
        .o_hit_x           (o_hit_x),
        .o_hit_y           (o_hit_y)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result words cannot be held off, so every strobe is checked as it comes.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_result(o_hit, o_hit_x, o_hit_y);
    end

    function automatic int clamp_coord(int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic path_word_t make_word(int t, int l, int b, int r, int sx, int sy,
                                             int wd, int ht, int tx, int ty);
        path_word_t w;
        w.obs_top    = COORD_BITS'(t);
        w.obs_left   = COORD_BITS'(l);
        w.obs_bottom = COORD_BITS'(b);
        w.obs_right  = COORD_BITS'(r);
        w.start_x    = COORD_BITS'(sx);
        w.start_y    = COORD_BITS'(sy);
        w.box_w      = (COORD_BITS-1)'(wd);
        w.box_h      = (COORD_BITS-1)'(ht);
        w.goal_x     = COORD_BITS'(tx);
        w.goal_y     = COORD_BITS'(ty);
        return w;
    endfunction

    // Mostly short paths with the obstacle placed on or near the line, so
    // that hits are common and each word keeps the engine busy only briefly.
    function automatic path_word_t random_word();
        int sel, reach, pct, sx, sy, tx, ty, px, py, t, l, b, r, wd, ht, tmp;
        sel = int'($urandom_range(99));
        sx = int'($urandom_range(4095)) - 2048;
        sy = int'($urandom_range(4095)) - 2048;
        wd = ($urandom_range(9) == 0) ? int'($urandom_range(2047)) : int'($urandom_range(12));
        ht = ($urandom_range(9) == 0) ? int'($urandom_range(2047)) : int'($urandom_range(12));
        if (sel < 8) begin
            tx = int'($urandom_range(4095)) - 2048;
            ty = int'($urandom_range(4095)) - 2048;
            t = int'($urandom_range(4095)) - 2048;
            l = int'($urandom_range(4095)) - 2048;
            b = int'($urandom_range(4095)) - 2048;
            r = int'($urandom_range(4095)) - 2048;
        end else begin
            reach = (sel < 18) ? 300 : 40;
            if (sel >= 95) begin
                tx = sx;
                ty = sy;
            end else begin
                tx = clamp_coord(sx + int'($urandom_range(2 * reach)) - reach);
                ty = clamp_coord(sy + int'($urandom_range(2 * reach)) - reach);
            end
            if (sel < 75) begin
                pct = int'($urandom_range(100));
                px = sx + (tx - sx) * pct / 100;
                py = sy + (ty - sy) * pct / 100;
            end else begin
                px = clamp_coord(sx + int'($urandom_range(120)) - 60);
                py = clamp_coord(sy + int'($urandom_range(120)) - 60);
            end
            l = clamp_coord(px - int'($urandom_range(8)));
            r = clamp_coord(l + int'($urandom_range(10)));
            t = clamp_coord(py - int'($urandom_range(8)));
            b = clamp_coord(t + int'($urandom_range(10)));
            if ($urandom_range(3) == 0) begin
                tmp = t;
                t = b;
                b = tmp;
            end
            if ($urandom_range(3) == 0) begin
                tmp = l;
                l = r;
                r = tmp;
            end
        end
        return make_word(t, l, b, r, sx, sy, wd, ht, tx, ty);
    endfunction

    task automatic send_word(input path_word_t w);
        @(negedge i_clk);
        start             <= 1'b1;
        i_obstacle_top    <= w.obs_top;
        i_obstacle_left   <= w.obs_left;
        i_obstacle_bottom <= w.obs_bottom;
        i_obstacle_right  <= w.obs_right;
        i_mover_left      <= w.start_x;
        i_mover_top       <= w.start_y;
        i_mover_width     <= w.box_w;
        i_mover_height    <= w.box_h;
        i_target_x        <= w.goal_x;
        i_target_y        <= w.goal_y;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        sb.note_word(w);
    endtask

    task automatic hold_start_low(input int unsigned cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1)
            @(negedge i_clk);
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned count, input int unsigned idle_pct);
        int unsigned gap;
        repeat (count) begin
            send_word(random_word());
            if ($urandom_range(99) < idle_pct) begin
                gap = ($urandom_range(3) == 0) ? $urandom_range(80, 10) : $urandom_range(6, 1);
                hold_start_low(gap);
            end
        end
        pause_until_drained();
    endtask

    initial begin
        sb = new();
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_obstacle_top    = '0;
        i_obstacle_left   = '0;
        i_obstacle_bottom = '0;
        i_obstacle_right  = '0;
        i_mover_left      = '0;
        i_mover_top       = '0;
        i_mover_width     = '0;
        i_mover_height    = '0;
        i_target_x        = '0;
        i_target_y        = '0;
        repeat (12)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero-length paths answer no hit, even when the box already overlaps.
        send_word(make_word(0, 0, 10, 10, 5, 5, 2, 2, 5, 5));
        send_word(make_word(100, 100, 110, 110, -2048, -2048, 0, 0, -2048, -2048));
        // The start corner is never tested, only the first step onwards.
        send_word(make_word(0, 0, 10, 10, 5, 5, 1, 1, 100, 5));
        // Straight runs on each axis; the edges touch inclusively.
        send_word(make_word(0, 50, 10, 60, 0, 0, 10, 0, 100, 0));
        send_word(make_word(0, -60, 10, -50, 0, 0, 0, 0, -100, 5));
        send_word(make_word(40, -5, 45, 5, 0, 0, 0, 0, 0, 100));
        send_word(make_word(20, -3, 30, 3, 0, 0, 0, 5, 0, 50));
        send_word(make_word(20, 6, 30, 9, 0, 0, 5, 0, 0, 50));
        // Obstacle given with both edge pairs the wrong way round.
        send_word(make_word(-40, 5, -45, -5, 0, 0, 3, 3, 0, -100));
        // Diagonals: one clean miss, one hit.
        send_word(make_word(100, -100, 120, -80, 0, 0, 5, 5, 200, 200));
        send_word(make_word(50, 50, 60, 60, 0, 0, 0, 0, 100, 100));
        // Halfway positions round away from zero, in both directions.
        send_word(make_word(1, 1, 1, 1, 0, 0, 0, 0, 2, 1));
        send_word(make_word(-1, -1, -1, -1, 0, 0, 0, 0, -2, -1));
        send_word(make_word(0, 2, 0, 3, 0, 0, 0, 0, 3, 1));
        send_word(make_word(-3, -2, -3, -2, 0, 0, 0, 0, -3, -7));
        // Full-range paths and boxes at the extremes of every field.
        send_word(make_word(2040, 2040, 2047, 2047, -2048, -2048, 0, 0, 2047, 2047));
        send_word(make_word(-2048, -2048, -2048, -2048, 2047, 2047, 2047, 2047,
                            -2048, -2048));
        send_word(make_word(-2048, 2047, 2047, 2047, -2048, -2048, 2047, 2047,
                            2047, -2048));
        send_word(make_word(-2048, -2048, 2047, 2047, -2048, 2047, 0, 0, -2048, 2046));
        send_word(make_word(2047, 2047, 2047, 2047, 2046, 2046, 0, 0, 2047, 2047));
        send_word(make_word(-1366, 1365, -1366, 1365, 1365, -1366, 1024, 682,
                            1300, -1300));
        pause_until_drained();

        run_random_phase(40, 24);
        run_random_phase(40, 77);
        run_random_phase(39, 0);

        repeat (8 * FRAC_BITS)
            @(posedge i_clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
